/* rtl/mcr_pkg.sv */
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared types and constants for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
package mcr_pkg;

    // default geometry
    localparam int COORD_WIDTH_DEF  = 12;
    localparam int RADIUS_WIDTH_DEF = 10;

    // width of every span coordinate on the result channel
    localparam int SPAN_W = 14;

    // input item codes
    typedef enum logic [1:0] {
        MODE_OUTLINE  = 2'd0,
        MODE_FILLED   = 2'd1,
        MODE_STEP     = 2'd2,
        MODE_STEP_ALT = 2'd3
    } t_mode;

    // per-transfer control from the loop unit to the result sequencer
    typedef struct packed {
        logic load;    // step item taken this cycle
        logic go;      // loop condition held: emit points or spans
        logic filled;  // filled mode (four spans) vs outline (eight points)
    } t_step_ctl;

endpackage

/* rtl/mcr_loop.sv */
// ----------------------------------------------------------------------------
// mcr_loop
// Circle loop state: loads on a start item, runs one midpoint iteration on
// each step item while the loop condition holds and reports the pre-update offsets to the sequencer.
// ----------------------------------------------------------------------------
module mcr_loop
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  t_mode                     i_mode,
    input  logic [COORD_WIDTH-1:0]    i_center_x,
    input  logic [COORD_WIDTH-1:0]    i_center_y,
    input  logic [RADIUS_WIDTH-1:0]   i_radius,
    output t_step_ctl                 o_ctl,
    output logic [COORD_WIDTH-1:0]    o_cx,
    output logic [COORD_WIDTH-1:0]    o_cy,
    output logic signed [RADIUS_WIDTH:0] o_x,
    output logic [RADIUS_WIDTH-1:0]   o_y
);

    localparam int DIAM_W = RADIUS_WIDTH + 1;
    localparam int STEP_W = RADIUS_WIDTH + 2;
    localparam int ERR_W  = RADIUS_WIDTH + 3;
    localparam int WIDE_W = ERR_W + 1;

    logic                      r_active, n_active;
    logic                      r_filled, n_filled;
    logic [COORD_WIDTH-1:0]    r_cx, n_cx;
    logic [COORD_WIDTH-1:0]    r_cy, n_cy;
    logic [DIAM_W-1:0]         r_diam, n_diam;
    logic signed [DIAM_W-1:0]  r_x, n_x;
    logic [RADIUS_WIDTH-1:0]   r_y, n_y;
    logic [STEP_W-1:0]         r_tx, n_tx;
    logic [STEP_W-1:0]         r_ty, n_ty;
    logic signed [ERR_W-1:0]   r_err, n_err;

    logic                      is_start;
    logic                      go;
    logic signed [WIDE_W-1:0]  err_a;
    logic signed [WIDE_W-1:0]  err_b;
    logic signed [ERR_W-1:0]   err_mid;
    logic signed [DIAM_W:0]    y_ext;

    assign is_start = (i_mode == MODE_OUTLINE) || (i_mode == MODE_FILLED);

    // loop condition on the current offsets
    assign y_ext = $signed({2'b00, r_y});
    assign go    = r_active && (r_filled ? ($signed({r_x[DIAM_W-1], r_x}) >= y_ext)
                                         : ($signed({r_x[DIAM_W-1], r_x}) >  y_ext));

    // midpoint iteration: minor step, then major step on the updated error
    assign err_a   = (r_err <= 0) ? (WIDE_W'(r_err) + $signed({2'b00, r_ty}))
                                  : WIDE_W'(r_err);
    assign err_mid = err_a[ERR_W-1:0];
    assign err_b   = WIDE_W'(err_mid) + $signed({2'b00, r_tx})
                     - $signed({{(WIDE_W-DIAM_W){1'b0}}, r_diam});

    // next state
    always_comb begin
        n_active = r_active;
        n_filled = r_filled;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_diam   = r_diam;
        n_x      = r_x;
        n_y      = r_y;
        n_tx     = r_tx;
        n_ty     = r_ty;
        n_err    = r_err;
        if (i_accept && is_start) begin
            n_active = 1'b1;
            n_filled = (i_mode == MODE_FILLED);
            n_cx     = i_center_x;
            n_cy     = i_center_y;
            n_diam   = {i_radius, 1'b0};
            n_x      = $signed({1'b0, i_radius}) - DIAM_W'(1);
            n_y      = '0;
            n_tx     = STEP_W'(1);
            n_ty     = STEP_W'(1);
            n_err    = ERR_W'(1) - $signed({2'b00, i_radius, 1'b0});
        end else if (i_accept && !go) begin
            n_active = 1'b0;
        end else if (i_accept) begin
            if (r_err <= 0) begin
                n_y  = r_y + RADIUS_WIDTH'(1);
                n_ty = r_ty + STEP_W'(2);
            end
            n_err = err_mid;
            if (err_mid > 0) begin
                n_x   = r_x - DIAM_W'(1);
                n_err = err_b[ERR_W-1:0];
                n_tx  = r_tx + STEP_W'(2);
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_filled <= 1'b0;
            r_cx     <= '0;
            r_cy     <= '0;
            r_diam   <= '0;
            r_x      <= '0;
            r_y      <= '0;
            r_tx     <= STEP_W'(1);
            r_ty     <= STEP_W'(1);
            r_err    <= '0;
        end else begin
            r_active <= n_active;
            r_filled <= n_filled;
            r_cx     <= n_cx;
            r_cy     <= n_cy;
            r_diam   <= n_diam;
            r_x      <= n_x;
            r_y      <= n_y;
            r_tx     <= n_tx;
            r_ty     <= n_ty;
            r_err    <= n_err;
        end
    end

    assign o_ctl.load   = i_accept && !is_start;
    assign o_ctl.go     = go;
    assign o_ctl.filled = r_filled;
    assign o_cx         = r_cx;
    assign o_cy         = r_cy;
    assign o_x          = r_x;
    assign o_y          = r_y;

endmodule

/* rtl/mcr_emit.sv */
// ----------------------------------------------------------------------------
// mcr_emit
// Result sequencer: holds one step's offsets and center and walks through
// its points or spans, one result transfer per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
module mcr_emit
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_step_ctl                    i_ctl,
    input  logic [COORD_WIDTH-1:0]       i_cx,
    input  logic [COORD_WIDTH-1:0]       i_cy,
    input  logic signed [RADIUS_WIDTH:0] i_x,
    input  logic [RADIUS_WIDTH-1:0]      i_y,
    input  logic                         i_out_stall,
    output logic                         o_busy_hold,
    output logic                         o_out_valid,
    output logic                         o_span_valid,
    output logic signed [SPAN_W-1:0]     o_span_x_start,
    output logic signed [SPAN_W-1:0]     o_span_x_end,
    output logic signed [SPAN_W-1:0]     o_span_row,
    output logic                         o_last_of_step,
    output logic                         o_circle_done
);

    localparam int MAX_W  = (COORD_WIDTH > RADIUS_WIDTH) ? COORD_WIDTH : RADIUS_WIDTH;
    localparam int CALC_W = (MAX_W + 2 > SPAN_W) ? MAX_W + 2 : SPAN_W;

    logic                         r_busy, n_busy;
    logic [2:0]                   r_idx, n_idx;
    logic                         r_go, n_go;
    logic                         r_filled, n_filled;
    logic [COORD_WIDTH-1:0]       r_cx, n_cx;
    logic [COORD_WIDTH-1:0]       r_cy, n_cy;
    logic signed [RADIUS_WIDTH:0] r_x, n_x;
    logic [RADIUS_WIDTH-1:0]      r_y, n_y;

    logic                         last;
    logic                         take;
    logic signed [CALC_W-1:0]     cxs, cys, xs, ys;
    logic signed [CALC_W-1:0]     c_xs, c_xe, c_row;

    // final result of the step being shown
    assign last = !r_go || (r_filled ? (r_idx == 3'd3) : (r_idx == 3'd7));
    assign take = r_busy && !i_out_stall;

    // input side waits unless the sequencer is idle or finishing now
    assign o_busy_hold = r_busy && !(take && last);

    // sequencer next state; a new step may load as the last result leaves
    always_comb begin
        n_busy   = r_busy;
        n_idx    = r_idx;
        n_go     = r_go;
        n_filled = r_filled;
        n_cx     = r_cx;
        n_cy     = r_cy;
        n_x      = r_x;
        n_y      = r_y;
        if (take) begin
            if (last) begin
                n_busy = 1'b0;
            end else begin
                n_idx = r_idx + 3'd1;
            end
        end
        if (i_ctl.load) begin
            n_busy   = 1'b1;
            n_idx    = '0;
            n_go     = i_ctl.go;
            n_filled = i_ctl.filled;
            n_cx     = i_cx;
            n_cy     = i_cy;
            n_x      = i_x;
            n_y      = i_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
            r_go   <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_idx  <= n_idx;
            r_go   <= n_go;
        end
    end

    // snapshot payload
    always_ff @(posedge i_clk) begin
        r_filled <= n_filled;
        r_cx     <= n_cx;
        r_cy     <= n_cy;
        r_x      <= n_x;
        r_y      <= n_y;
    end

    // operands, sign-correct at calculation width
    assign cxs = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, r_cx});
    assign cys = $signed({{(CALC_W-COORD_WIDTH){1'b0}}, r_cy});
    assign xs  = $signed({{(CALC_W-RADIUS_WIDTH-1){r_x[RADIUS_WIDTH]}}, r_x});
    assign ys  = $signed({{(CALC_W-RADIUS_WIDTH){1'b0}}, r_y});

    // point or span select
    always_comb begin
        c_xs  = '0;
        c_xe  = '0;
        c_row = '0;
        if (r_filled) begin
            case (r_idx[1:0])
                2'd0: begin c_xs = cxs - xs; c_xe = cxs + xs; c_row = cys + ys; end
                2'd1: begin c_xs = cxs - xs; c_xe = cxs + xs; c_row = cys - ys; end
                2'd2: begin c_xs = cxs - ys; c_xe = cxs + ys; c_row = cys + xs; end
                default: begin c_xs = cxs - ys; c_xe = cxs + ys; c_row = cys - xs; end
            endcase
        end else begin
            case (r_idx)
                3'd0: begin c_xs = cxs + xs; c_row = cys - ys; end
                3'd1: begin c_xs = cxs + xs; c_row = cys + ys; end
                3'd2: begin c_xs = cxs - xs; c_row = cys - ys; end
                3'd3: begin c_xs = cxs - xs; c_row = cys + ys; end
                3'd4: begin c_xs = cxs + ys; c_row = cys - xs; end
                3'd5: begin c_xs = cxs + ys; c_row = cys + xs; end
                3'd6: begin c_xs = cxs - ys; c_row = cys - xs; end
                default: begin c_xs = cxs - ys; c_row = cys + xs; end
            endcase
            c_xe = c_xs;
        end
    end

    // result channel; the done result carries zero span fields
    assign o_out_valid    = r_busy;
    assign o_span_valid   = r_go;
    assign o_span_x_start = r_go ? c_xs[SPAN_W-1:0]  : '0;
    assign o_span_x_end   = r_go ? c_xe[SPAN_W-1:0]  : '0;
    assign o_span_row     = r_go ? c_row[SPAN_W-1:0] : '0;
    assign o_last_of_step = last;
    assign o_circle_done  = !r_go;

endmodule

/* rtl/midpoint_circle_rasterizer_top.sv */
// Latency: a step item's first result is offered the cycle after its transfer.
// Throughput: one result per cycle from the result sequencer while the output
//   is not stalled; a step item gives eight points in outline mode, four spans
//   in filled mode or the done result; a start item gives no result.
// The next item is taken in the cycle the previous step's last result leaves.
// Reset (synchronous, active low): no circle active, no result pending.
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_top
// Midpoint circle rasterizer: outline points or filled spans, one loop
// iteration per step item.
// ----------------------------------------------------------------------------
module midpoint_circle_rasterizer_top
    import mcr_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [1:0]               i_mode,
    input  logic [COORD_WIDTH-1:0]   i_center_x,
    input  logic [COORD_WIDTH-1:0]   i_center_y,
    input  logic [RADIUS_WIDTH-1:0]  i_radius,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_span_valid,
    output logic signed [SPAN_W-1:0] o_span_x_start,
    output logic signed [SPAN_W-1:0] o_span_x_end,
    output logic signed [SPAN_W-1:0] o_span_row,
    output logic                     o_last_of_step,
    output logic                     o_circle_done
);

    t_step_ctl                    ctl;
    logic                         in_xfer;
    logic                         busy_hold;
    logic [COORD_WIDTH-1:0]       cx, cy;
    logic signed [RADIUS_WIDTH:0] x;
    logic [RADIUS_WIDTH-1:0]      y;

    // input transfer
    assign o_in_stall = busy_hold;
    assign in_xfer    = i_in_valid && !busy_hold;

    mcr_loop #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_loop (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (in_xfer),
        .i_mode     (t_mode'(i_mode)),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_ctl      (ctl),
        .o_cx       (cx),
        .o_cy       (cy),
        .o_x        (x),
        .o_y        (y)
    );

    mcr_emit #(
        .COORD_WIDTH  (COORD_WIDTH),
        .RADIUS_WIDTH (RADIUS_WIDTH)
    ) u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .i_cx           (cx),
        .i_cy           (cy),
        .i_x            (x),
        .i_y            (y),
        .i_out_stall    (i_out_stall),
        .o_busy_hold    (busy_hold),
        .o_out_valid    (o_out_valid),
        .o_span_valid   (o_span_valid),
        .o_span_x_start (o_span_x_start),
        .o_span_x_end   (o_span_x_end),
        .o_span_row     (o_span_row),
        .o_last_of_step (o_last_of_step),
        .o_circle_done  (o_circle_done)
    );

endmodule

/* rtl/mcr_checker.sv */
// ----------------------------------------------------------------------------
// mcr_checker
// Port-level checks on the result channel of the circle rasterizer.
// ----------------------------------------------------------------------------
module mcr_checker
    import mcr_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic                     o_span_valid,
    input logic signed [SPAN_W-1:0] o_span_x_start,
    input logic signed [SPAN_W-1:0] o_span_x_end,
    input logic signed [SPAN_W-1:0] o_span_row,
    input logic                     o_last_of_step,
    input logic                     o_circle_done
);

    // done result is a lone, empty, final result
    a_done_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_circle_done |->
            o_last_of_step && !o_span_valid && o_span_x_start == '0
            && o_span_x_end == '0 && o_span_row == '0)
        else $error("done result malformed");

    // every result is either a span or the done marker
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_span_valid != o_circle_done))
        else $error("result is neither span nor done");

    // spans never run right to left
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_span_valid |-> o_span_x_start <= o_span_x_end)
        else $error("span start right of end");

    // a non-final result in flight keeps the input side waiting
    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last_of_step |-> o_in_stall)
        else $error("input taken mid step");

    // stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_span_row)
            && $stable(o_span_x_start) && $stable(o_span_x_end))
        else $error("stalled result changed");

endmodule

bind midpoint_circle_rasterizer_top mcr_checker u_mcr_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_span_valid   (o_span_valid),
    .o_span_x_start (o_span_x_start),
    .o_span_x_end   (o_span_x_end),
    .o_span_row     (o_span_row),
    .o_last_of_step (o_last_of_step),
    .o_circle_done  (o_circle_done)
);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for midpoint_circle_rasterizer_top. A behavioral
// rasterizer tracks the circle state, predicts the points, spans and done
// results of every item taken, and checks each result taken from the block
// field by field. Directed cases come first, then random circles under
// several idle/stall mixes.
// ----------------------------------------------------------------------------
module tb;
    import mcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW          = COORD_WIDTH_DEF;
    localparam int RW          = RADIUS_WIDTH_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 200;

    // one result as seen on the output channel
    typedef struct {
        logic                     span_valid;
        logic signed [SPAN_W-1:0] x_start;
        logic signed [SPAN_W-1:0] x_end;
        logic signed [SPAN_W-1:0] row;
        logic                     last;
        logic                     done;
    } t_span;

    // DUT ports
    logic                     i_clk          = 1'b0;
    logic                     i_rst_n        = 1'b0;
    logic                     i_in_valid     = 1'b0;
    logic                     o_in_stall;
    logic [1:0]               i_mode         = MODE_STEP;
    logic [CW-1:0]            i_center_x     = '0;
    logic [CW-1:0]            i_center_y     = '0;
    logic [RW-1:0]            i_radius       = '0;
    logic                     o_out_valid;
    logic                     i_out_stall    = 1'b0;
    logic                     o_span_valid;
    logic signed [SPAN_W-1:0] o_span_x_start;
    logic signed [SPAN_W-1:0] o_span_x_end;
    logic signed [SPAN_W-1:0] o_span_row;
    logic                     o_last_of_step;
    logic                     o_circle_done;

    // rasterizer state mirror
    logic                     circ_active = 1'b0;
    logic                     circ_filled = 1'b0;
    logic [CW-1:0]            circ_cx     = '0;
    logic [CW-1:0]            circ_cy     = '0;
    logic signed [11:0]       circ_diam   = '0;
    logic signed [10:0]       circ_x      = '0;
    logic signed [10:0]       circ_y      = '0;
    logic signed [12:0]       circ_tx     = 13'sd1;
    logic signed [12:0]       circ_ty     = 13'sd1;
    logic signed [12:0]       circ_err    = '0;

    t_span pending_spans[$];

    int mismatches     = 0;
    int items_sent     = 0;
    int cycles         = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    midpoint_circle_rasterizer_top DUT (.*);

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time,
                     pending_spans.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    function automatic void push_span(logic valid, int xs, int xe, int row,
                                      logic last, logic done);
        t_span s;
        s.span_valid = valid;
        s.x_start    = SPAN_W'(xs);
        s.x_end      = SPAN_W'(xe);
        s.row        = SPAN_W'(row);
        s.last       = last;
        s.done       = done;
        pending_spans.push_back(s);
    endfunction

    // one midpoint iteration per step item while the loop condition holds; start items only load state
    function automatic void rasterize_item(t_mode m, logic [CW-1:0] cx_in,
                                           logic [CW-1:0] cy_in,
                                           logic [RW-1:0] r_in);
        int  cx;
        int  cy;
        int  x;
        int  y;
        logic go;
        if (m == MODE_OUTLINE || m == MODE_FILLED) begin
            circ_filled = (m == MODE_FILLED);
            circ_cx     = cx_in;
            circ_cy     = cy_in;
            circ_diam   = $signed({1'b0, r_in, 1'b0});
            circ_x      = $signed({1'b0, r_in}) - 11'sd1;
            circ_y      = '0;
            circ_tx     = 13'sd1;
            circ_ty     = 13'sd1;
            circ_err    = 13'sd1 - 13'(circ_diam);
            circ_active = 1'b1;
            return;
        end
        go = circ_active && (circ_filled ? (circ_x >= circ_y) : (circ_x > circ_y));
        if (!go) begin
            circ_active = 1'b0;
            push_span(1'b0, 0, 0, 0, 1'b1, 1'b1);
            return;
        end
        cx = int'(circ_cx);
        cy = int'(circ_cy);
        x  = int'(circ_x);
        y  = int'(circ_y);
        if (circ_filled) begin
            push_span(1'b1, cx - x, cx + x, cy + y, 1'b0, 1'b0);
            push_span(1'b1, cx - x, cx + x, cy - y, 1'b0, 1'b0);
            push_span(1'b1, cx - y, cx + y, cy + x, 1'b0, 1'b0);
            push_span(1'b1, cx - y, cx + y, cy - x, 1'b1, 1'b0);
        end else begin
            push_span(1'b1, cx + x, cx + x, cy - y, 1'b0, 1'b0);
            push_span(1'b1, cx + x, cx + x, cy + y, 1'b0, 1'b0);
            push_span(1'b1, cx - x, cx - x, cy - y, 1'b0, 1'b0);
            push_span(1'b1, cx - x, cx - x, cy + y, 1'b0, 1'b0);
            push_span(1'b1, cx + y, cx + y, cy - x, 1'b0, 1'b0);
            push_span(1'b1, cx + y, cx + y, cy + x, 1'b0, 1'b0);
            push_span(1'b1, cx - y, cx - y, cy - x, 1'b0, 1'b0);
            push_span(1'b1, cx - y, cx - y, cy + x, 1'b1, 1'b0);
        end
        // error update: minor axis first, then major with the new error
        if (circ_err <= 0) begin
            circ_y   = circ_y + 11'sd1;
            circ_err = circ_err + circ_ty;
            circ_ty  = circ_ty + 13'sd2;
        end
        if (circ_err > 0) begin
            circ_x   = circ_x - 11'sd1;
            circ_err = circ_err + circ_tx - 13'(circ_diam);
            circ_tx  = circ_tx + 13'sd2;
        end
    endfunction

    function automatic void check_field(string name, logic signed [SPAN_W-1:0] exp_v,
                                        logic signed [SPAN_W-1:0] act_v);
        if (act_v !== exp_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("%0t: %s mismatch: expected %0d, got %0d",
                         $time, name, exp_v, act_v);
        end
    endfunction

    // input transfers feed the predictor, output transfers are checked
    always @(posedge i_clk) begin
        t_span s;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                rasterize_item(t_mode'(i_mode), i_center_x, i_center_y, i_radius);
            if (o_out_valid && !i_out_stall) begin
                if (pending_spans.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result: expected none, got row %0d",
                                 $time, o_span_row);
                end else begin
                    s = pending_spans.pop_front();
                    check_field("span_valid",   SPAN_W'(s.span_valid),
                                SPAN_W'(o_span_valid));
                    check_field("span_x_start", s.x_start,    o_span_x_start);
                    check_field("span_x_end",   s.x_end,      o_span_x_end);
                    check_field("span_row",     s.row,        o_span_row);
                    check_field("last_of_step", SPAN_W'(s.last),
                                SPAN_W'(o_last_of_step));
                    check_field("circle_done",  SPAN_W'(s.done),
                                SPAN_W'(o_circle_done));
                end
            end
        end
    end

    // drive one item from a falling edge and hold it until its transfer
    task automatic send_item(input t_mode m, input logic [CW-1:0] cx,
                             input logic [CW-1:0] cy, input logic [RW-1:0] r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 16) gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode     <= m;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius   <= r;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        @(negedge i_clk);
    endtask

    // step item with junk in the unused fields; the alternate code now and then
    task automatic send_step();
        send_item(($urandom_range(3) == 0) ? MODE_STEP_ALT : MODE_STEP,
                  CW'($urandom_range(4095)), CW'($urandom_range(4095)),
                  RW'($urandom_range(1023)));
    endtask

    // steps with no circle loaded give the done result
    task automatic test_step_before_start();
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_STEP_ALT, 12'hFFF, 12'hFFF, 10'h3FF);
    endtask

    // zero radius ends before the first iteration
    task automatic test_zero_radius();
        send_item(MODE_OUTLINE, 12'd100, 12'd200, 10'd0);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_FILLED, 12'd300, 12'd400, 10'd0);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
    endtask

    // radius one: outline ends at once, filled emits one row of spans
    task automatic test_radius_one();
        send_item(MODE_OUTLINE, 12'd50, 12'd60, 10'd1);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_FILLED, 12'd70, 12'd80, 10'd1);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
    endtask

    // a complete small outline run
    task automatic test_small_circle();
        send_item(MODE_OUTLINE, 12'h555, 12'hAAA, 10'd2);
        while (circ_active) send_item(MODE_STEP, 12'hAAA, 12'h555, 10'h2AA);
    endtask

    // largest radius at the corners: negative and wide coordinates,
    // plus a restart that abandons the running circle
    task automatic test_coordinate_extremes();
        send_item(MODE_FILLED, 12'd0, 12'd0, 10'h3FF);
        repeat (3) send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_OUTLINE, 12'hFFF, 12'hFFF, 10'h3FF);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
        send_item(MODE_STEP_ALT, 12'd0, 12'd0, 10'd0);
        send_item(MODE_STEP, 12'd0, 12'd0, 10'd0);
    endtask

    // whole circles with random content, some abandoned, some noise items
    task automatic test_random_circles(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int          stop_at;
        int          roll;
        int          budget;
        t_mode       start_mode;
        logic [RW-1:0] r;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                send_item(t_mode'($urandom_range(3)), CW'($urandom_range(4095)),
                          CW'($urandom_range(4095)), RW'($urandom_range(1023)));
            end else begin
                start_mode = $urandom_range(1) ? MODE_FILLED : MODE_OUTLINE;
                r = (roll < 80) ? RW'($urandom_range(24)) : RW'($urandom_range(1023, 25));
                send_item(start_mode, CW'($urandom_range(4095)),
                          CW'($urandom_range(4095)), r);
                budget = (r > 24) ? $urandom_range(8, 1) : 1000;
                if ($urandom_range(9) == 0) budget = $urandom_range(3);
                while (circ_active && budget > 0 && items_sent < stop_at) begin
                    send_step();
                    budget--;
                end
                // occasionally step past the end
                if ($urandom_range(2) == 0 && items_sent < stop_at) send_step();
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_step_before_start();
        test_zero_radius();
        test_radius_one();
        test_small_circle();
        test_coordinate_extremes();

        test_random_circles(37, 0, 0);
        test_random_circles(37, 68, 0);
        test_random_circles(37, 0, 68);
        test_random_circles(37, 21, 21);

        i_in_valid <= 1'b0;
        while (pending_spans.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        if (mismatches == 0 && pending_spans.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* files.f */
rtl/mcr_pkg.sv
rtl/mcr_loop.sv
rtl/mcr_emit.sv
rtl/midpoint_circle_rasterizer_top.sv
rtl/mcr_checker.sv
tb/tb.sv
